// File: sv/hgsr_pkg.sv
// ----------------------------------------------------------------------------
// hgsr_pkg
// Shared widths, limits, codes and the configuration record of the HMM Gibbs
// state resampler.
// ----------------------------------------------------------------------------
package hgsr_pkg;

   // table geometry
   localparam int MAX_STATES  = 16;
   localparam int STATE_BITS  = 4;
   localparam int K_BITS      = STATE_BITS + 1;
   localparam int MAX_VOCAB   = 4096;
   localparam int VOCAB_BITS  = 12;
   localparam int V_BITS      = VOCAB_BITS + 1;
   localparam int COUNT_BITS  = 20;
   localparam int T_DEPTH     = MAX_STATES * MAX_STATES;
   localparam int E_DEPTH     = MAX_STATES * MAX_VOCAB;

   // fixed point
   localparam int PRIOR_BITS  = 16;
   localparam int FRAC_BITS   = 8;
   localparam int Q_BITS      = 32;
   localparam int DIV_BITS    = 30;
   localparam int WEIGHT_BITS = 58;
   localparam int SUM_BITS    = WEIGHT_BITS + STATE_BITS;

   // configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // commands and result status
   localparam logic       CMD_COUNT    = 1'b0;
   localparam logic       CMD_RESAMPLE = 1'b1;
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CLAMP = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // register indexes
   typedef enum logic [1:0] {
      REG_NUM_STATES = 2'd0,
      REG_VOCAB_SIZE = 2'd1,
      REG_ALPHA      = 2'd2,
      REG_BETA       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [K_BITS-1:0]     num_states;
      logic [V_BITS-1:0]     vocab_size;
      logic [PRIOR_BITS-1:0] alpha;
      logic [PRIOR_BITS-1:0] beta;
   } cfg_type;

endpackage

// File: sv/hgsr_ram.sv
// ----------------------------------------------------------------------------
// hgsr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hgsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hgsr_div.sv
// ----------------------------------------------------------------------------
// hgsr_div
// Q32 quotient num/den, truncated and clamped below one; restoring divider,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hgsr_div import hgsr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] num,
   input  logic [DIV_BITS-1:0] den,
   output logic [Q_BITS-1:0]   quo,
   output logic                clamp,
   output logic                done
);

   localparam int CNT_BITS = $clog2(Q_BITS);

   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] den_ff;
   logic [Q_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff, done_ff, clamp_ff;
   logic [DIV_BITS:0]   rem_shift;

   // one restoring step
   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      if (rem_shift >= {1'b0, den_ff}) begin
         rem_in = DIV_BITS'(rem_shift - {1'b0, den_ff});
         quo_in = {quo_ff[Q_BITS-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[DIV_BITS-1:0];
         quo_in = {quo_ff[Q_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         priority if (den == '0) begin
            quo_ff   <= (num != '0) ? '1 : '0;
            clamp_ff <= (num != '0);
            busy_ff  <= 1'b0;
            done_ff  <= 1'b1;
         end else if (num >= den) begin
            quo_ff   <= '1;
            clamp_ff <= (num > den);
            busy_ff  <= 1'b0;
            done_ff  <= 1'b1;
         end else begin
            rem_ff   <= num;
            den_ff   <= den;
            quo_ff   <= '0;
            clamp_ff <= 1'b0;
            cnt_ff   <= '0;
            busy_ff  <= 1'b1;
            done_ff  <= 1'b0;
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(Q_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quo   = quo_ff;
   assign clamp = clamp_ff;
   assign done  = done_ff;

endmodule

// File: sv/hgsr_csr.sv
// ----------------------------------------------------------------------------
// hgsr_csr
// APB register file: num_states, vocab_size, alpha, beta.
// ----------------------------------------------------------------------------
module hgsr_csr import hgsr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   reg_index_type sel;
   logic          wr_en;

   assign sel        = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_states <= K_BITS'(16);
         cfg_ff.vocab_size <= V_BITS'(4096);
         cfg_ff.alpha      <= PRIOR_BITS'(256);
         cfg_ff.beta       <= PRIOR_BITS'(256);
      end else if (wr_en) begin
         unique case (sel)
            REG_NUM_STATES: cfg_ff.num_states <= csr_pwdata[K_BITS-1:0];
            REG_VOCAB_SIZE: cfg_ff.vocab_size <= csr_pwdata[V_BITS-1:0];
            REG_ALPHA:      cfg_ff.alpha      <= csr_pwdata[PRIOR_BITS-1:0];
            REG_BETA:       cfg_ff.beta       <= csr_pwdata[PRIOR_BITS-1:0];
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (sel)
         REG_NUM_STATES: csr_prdata = CSR_DATA_BITS'(cfg_ff.num_states);
         REG_VOCAB_SIZE: csr_prdata = CSR_DATA_BITS'(cfg_ff.vocab_size);
         REG_ALPHA:      csr_prdata = CSR_DATA_BITS'(cfg_ff.alpha);
         REG_BETA:       csr_prdata = CSR_DATA_BITS'(cfg_ff.beta);
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/hmm_gibbs_state_resampler_top.sv
// ----------------------------------------------------------------------------
// hmm_gibbs_state_resampler_top
// Count tables of a collapsed Gibbs sampler for a Bayesian HMM, with a
// count command and a resample command per token.
// ----------------------------------------------------------------------------
//  channel | ports   | transfer moves
//  --------+---------+----------------------------------------------
//  input   | req_*   | one token: command, word, labels, flags, draw
//  result  | rsp_*   | sampled state and status
//  config  | csr_*   | APB register writes and reads
//
// A resample works through every state in turn; the serial divider, one
// quotient bit a cycle, paces the work on each state.  After reset a clearing
// pass over every table address zeroes the tables; no token is taken
// meanwhile.  One token is worked at a time; a held result does not block
// acceptance of the next, but that token waits to hand over its result.
// ----------------------------------------------------------------------------
module hmm_gibbs_state_resampler_top import hgsr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // word[11:0] cur[15:12] prev[19:16] next[23:20] has_prev[24]
   // has_next[25] random_draw[57:26]
   input  logic [63:0]              req_tdata,
   // command[0]
   input  logic [0:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // new_state[3:0]
   output logic [7:0]               rsp_tdata,
   // status[1:0]
   output logic [1:0]               rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int T_ADDR_BITS = 2 * STATE_BITS;
   localparam int E_ADDR_BITS = STATE_BITS + VOCAB_BITS;
   localparam int TERM_BITS   = COUNT_BITS + FRAC_BITS + 1;
   localparam int VB_BITS     = V_BITS + PRIOR_BITS;
   localparam int KA_BITS     = K_BITS + PRIOR_BITS;
   localparam int PW_BITS     = Q_BITS + TERM_BITS - FRAC_BITS;
   localparam logic [DIV_BITS-1:0]    ONE_Q8    = DIV_BITS'(1) << FRAC_BITS;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
   localparam logic [1:0] STEP_PREV = 2'd0;
   localparam logic [1:0] STEP_NEXT = 2'd1;
   localparam logic [1:0] STEP_EMIT = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_K_RD0, ST_K_RD1, ST_K_LD,
      ST_K_DIV, ST_K_MUL, ST_THR1, ST_THR2, ST_SEL_RD, ST_SEL_CHK, ST_DONE
   } state_type;

   // saturating count step: {clamp, value}
   function automatic logic [COUNT_BITS:0] count_step(logic [COUNT_BITS-1:0] c,
                                                      logic up);
      logic [COUNT_BITS:0] r;
      if (up) begin
         r = (c == COUNT_MAX) ? {1'b1, c} : {1'b0, c + 1'b1};
      end else begin
         r = (c == '0) ? {1'b1, c} : {1'b0, c - 1'b1};
      end
      return r;
   endfunction

   cfg_type cfg;

   hgsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input fields
   logic                  in_cmd, in_hp, in_hn;
   logic [VOCAB_BITS-1:0] in_word;
   logic [STATE_BITS-1:0] in_cur, in_prv, in_nxt;
   logic [Q_BITS-1:0]     in_rnd;
   logic                  in_bad, accept;

   assign in_cmd  = req_tuser[0];
   assign in_word = req_tdata[11:0];
   assign in_cur  = req_tdata[15:12];
   assign in_prv  = req_tdata[19:16];
   assign in_nxt  = req_tdata[23:20];
   assign in_hp   = req_tdata[24];
   assign in_hn   = req_tdata[25];
   assign in_rnd  = req_tdata[57:26];

   // range check
   assign in_bad = (cfg.num_states < K_BITS'(2)) ||
                   (cfg.num_states > K_BITS'(MAX_STATES)) ||
                   (cfg.vocab_size < V_BITS'(1)) ||
                   (cfg.vocab_size > V_BITS'(MAX_VOCAB)) ||
                   (cfg.alpha == '0) || (cfg.beta == '0) ||
                   ({1'b0, in_word} >= cfg.vocab_size) ||
                   ({1'b0, in_cur} >= cfg.num_states) ||
                   (in_hn && ({1'b0, in_nxt} >= cfg.num_states)) ||
                   ((in_cmd == CMD_RESAMPLE) && in_hp &&
                    ({1'b0, in_prv} >= cfg.num_states));

   // control and item registers
   state_type             state_ff;
   logic [E_ADDR_BITS-1:0] clr_ff;
   logic                  cmd_ff, hp_ff, hn_ff, bad_ff, up_ff, clamp_ff;
   logic [VOCAB_BITS-1:0] word_ff;
   logic [STATE_BITS-1:0] cur_ff, prv_ff, nxt_ff, s_ff;
   logic [Q_BITS-1:0]     rnd_ff;
   logic [1:0]            step_ff;
   logic [K_BITS-1:0]     k_ff;
   logic [VB_BITS-1:0]    vbeta_ff;
   logic [KA_BITS-1:0]    kalpha_ff;
   logic [COUNT_BITS-1:0] e_q_ff, s_q_ff, o_q_ff;
   logic [TERM_BITS-1:0]  t2_ff;
   logic [Q_BITS-1:0]     p_ff;
   logic [SUM_BITS-1:0]   sum_ff, thr_ff, cum_ff, thr_hi_ff;
   logic [Q_BITS-1:0]     thr_lo_ff;
   logic                  rsp_valid_ff;
   logic [STATE_BITS-1:0] rsp_state_ff;
   logic [1:0]            rsp_status_ff;

   logic [STATE_BITS-1:0] k_idx;
   assign k_idx  = k_ff[STATE_BITS-1:0];
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // memory ports
   logic                   t_we, o_we, e_we, s_we, w_we;
   logic [T_ADDR_BITS-1:0] t_waddr, t_raddr, upd_t_addr;
   logic [STATE_BITS-1:0]  o_waddr, o_raddr, upd_o_addr, s_waddr, s_raddr;
   logic [E_ADDR_BITS-1:0] e_waddr, e_raddr;
   logic [COUNT_BITS-1:0]  t_wdata, o_wdata, e_wdata, s_wdata;
   logic [COUNT_BITS-1:0]  t_rdata, o_rdata, e_rdata, s_rdata;
   logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
   logic [COUNT_BITS:0]    t_mod, o_mod, e_mod, s_mod;

   hgsr_ram #(.WIDTH(COUNT_BITS), .DEPTH(T_DEPTH)) u_trans (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data(t_rdata));
   hgsr_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_STATES)) u_outgoing (
      .clock(clock), .wr_en(o_we), .wr_addr(o_waddr), .wr_data(o_wdata),
      .rd_addr(o_raddr), .rd_data(o_rdata));
   hgsr_ram #(.WIDTH(COUNT_BITS), .DEPTH(E_DEPTH)) u_emission (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
      .rd_addr(e_raddr), .rd_data(e_rdata));
   hgsr_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_STATES)) u_totals (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata));
   hgsr_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_STATES)) u_weights (
      .clock(clock), .wr_en(w_we), .wr_addr(k_idx), .wr_data(w_wdata),
      .rd_addr(k_idx), .rd_data(w_rdata));

   // update step addresses: link into s, link out of s, emission of s
   assign upd_t_addr = (step_ff == STEP_PREV) ? {prv_ff, s_ff} : {s_ff, nxt_ff};
   assign upd_o_addr = (step_ff == STEP_PREV) ? prv_ff : s_ff;

   assign t_mod = count_step(t_rdata, up_ff);
   assign o_mod = count_step(o_rdata, up_ff);
   assign e_mod = count_step(e_rdata, up_ff);
   assign s_mod = count_step(s_rdata, up_ff);

   always_comb begin
      unique case (state_ff)
         ST_K_RD0: t_raddr = {prv_ff, k_idx};
         ST_K_RD1: t_raddr = {k_idx, nxt_ff};
         default:  t_raddr = upd_t_addr;
      endcase
   end
   assign o_raddr = (state_ff == ST_K_RD0) ? k_idx : upd_o_addr;
   assign e_raddr = (state_ff == ST_K_RD0) ? {k_idx, word_ff} : {s_ff, word_ff};
   assign s_raddr = (state_ff == ST_K_RD0) ? k_idx : s_ff;

   // writes: clearing pass or read-modify-write
   logic clearing, upd_wr;
   assign clearing = (state_ff == ST_CLEAR);
   assign upd_wr   = (state_ff == ST_UPD_WR);
   assign t_we     = clearing || (upd_wr && (step_ff != STEP_EMIT));
   assign o_we     = t_we;
   assign e_we     = clearing || (upd_wr && (step_ff == STEP_EMIT));
   assign s_we     = e_we;
   assign t_waddr  = clearing ? clr_ff[T_ADDR_BITS-1:0] : upd_t_addr;
   assign o_waddr  = clearing ? clr_ff[STATE_BITS-1:0] : upd_o_addr;
   assign e_waddr  = clearing ? clr_ff : {s_ff, word_ff};
   assign s_waddr  = clearing ? clr_ff[STATE_BITS-1:0] : s_ff;
   assign t_wdata  = clearing ? '0 : t_mod[COUNT_BITS-1:0];
   assign o_wdata  = clearing ? '0 : o_mod[COUNT_BITS-1:0];
   assign e_wdata  = clearing ? '0 : e_mod[COUNT_BITS-1:0];
   assign s_wdata  = clearing ? '0 : s_mod[COUNT_BITS-1:0];

   // step enables
   logic step_en;
   always_comb begin
      unique case (step_ff)
         STEP_PREV: step_en = (cmd_ff == CMD_RESAMPLE) && hp_ff;
         STEP_NEXT: step_en = hn_ff;
         default:   step_en = 1'b1;
      endcase
   end

   // divider operands
   logic                same_p, same_pn, div_start;
   logic [DIV_BITS-1:0] num1, den1, num3, den3;
   logic [Q_BITS-1:0]   q1, q3;
   logic                c1, c3, d1, d3;

   assign same_p  = hp_ff && (prv_ff == k_idx);
   assign same_pn = same_p && (k_idx == nxt_ff);
   assign num1 = DIV_BITS'({e_q_ff, {FRAC_BITS{1'b0}}}) + DIV_BITS'(cfg.beta);
   assign den1 = DIV_BITS'({s_q_ff, {FRAC_BITS{1'b0}}}) + DIV_BITS'(vbeta_ff);
   assign num3 = DIV_BITS'({t_rdata, {FRAC_BITS{1'b0}}}) + DIV_BITS'(cfg.alpha) +
                 (same_pn ? ONE_Q8 : '0);
   assign den3 = DIV_BITS'({o_q_ff, {FRAC_BITS{1'b0}}}) + DIV_BITS'(kalpha_ff) +
                 (same_p ? ONE_Q8 : '0);
   assign div_start = (state_ff == ST_K_LD);

   hgsr_div u_div_emit (
      .clock(clock), .reset(reset), .start(div_start), .num(num1), .den(den1),
      .quo(q1), .clamp(c1), .done(d1));
   hgsr_div u_div_trans (
      .clock(clock), .reset(reset), .start(div_start), .num(num3), .den(den3),
      .quo(q3), .clamp(c3), .done(d3));

   // weight arithmetic
   logic [2*Q_BITS-1:0]         p_prod;
   logic [Q_BITS+TERM_BITS-1:0] w_prod;
   logic [PW_BITS-1:0]          w_shift;
   logic                        w_sat;
   logic [SUM_BITS-1:0]         cum_in;
   logic [2*Q_BITS-1:0]         thr_lo_prod;

   assign p_prod  = q1 * q3;
   assign w_prod  = p_ff * t2_ff;
   assign w_shift = w_prod[Q_BITS+TERM_BITS-1:FRAC_BITS];
   assign w_sat   = hp_ff && (SUM_BITS'(w_shift) > SUM_BITS'(WEIGHT_MAX));
   assign w_wdata = !hp_ff ? WEIGHT_BITS'(p_ff) :
                    (w_sat ? WEIGHT_MAX : WEIGHT_BITS'(w_shift));
   assign w_we    = (state_ff == ST_K_MUL);
   assign cum_in  = cum_ff + SUM_BITS'(w_rdata);

   // low half of the threshold product, full width
   assign thr_lo_prod = sum_ff[Q_BITS-1:0] * rnd_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff    <= in_cmd;
                  word_ff   <= in_word;
                  cur_ff    <= in_cur;
                  prv_ff    <= in_prv;
                  nxt_ff    <= in_nxt;
                  hp_ff     <= in_hp;
                  hn_ff     <= in_hn;
                  rnd_ff    <= in_rnd;
                  s_ff      <= in_cur;
                  bad_ff    <= in_bad;
                  clamp_ff  <= 1'b0;
                  up_ff     <= (in_cmd != CMD_RESAMPLE);
                  step_ff   <= STEP_PREV;
                  vbeta_ff  <= cfg.vocab_size * cfg.beta;
                  kalpha_ff <= cfg.num_states * cfg.alpha;
                  state_ff  <= in_bad ? ST_DONE : ST_UPD_RD;
               end
            end
            ST_UPD_RD: begin
               if (step_en) begin
                  state_ff <= ST_UPD_WR;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_UPD_WR: begin
               if (step_ff == STEP_EMIT) begin
                  clamp_ff <= clamp_ff | e_mod[COUNT_BITS] | s_mod[COUNT_BITS];
                  if (up_ff) begin
                     state_ff <= ST_DONE;
                  end else begin
                     k_ff     <= '0;
                     sum_ff   <= '0;
                     state_ff <= ST_K_RD0;
                  end
               end else begin
                  clamp_ff <= clamp_ff | t_mod[COUNT_BITS] | o_mod[COUNT_BITS];
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_UPD_RD;
               end
            end
            ST_K_RD0: begin
               state_ff <= ST_K_RD1;
            end
            ST_K_RD1: begin
               e_q_ff   <= e_rdata;
               s_q_ff   <= s_rdata;
               o_q_ff   <= o_rdata;
               t2_ff    <= TERM_BITS'({t_rdata, {FRAC_BITS{1'b0}}}) +
                           TERM_BITS'(cfg.alpha);
               state_ff <= ST_K_LD;
            end
            ST_K_LD: begin
               state_ff <= ST_K_DIV;
            end
            ST_K_DIV: begin
               if (d1 && d3) begin
                  clamp_ff <= clamp_ff | c1 | (hn_ff & c3);
                  p_ff     <= hn_ff ? p_prod[2*Q_BITS-1:Q_BITS] : q1;
                  state_ff <= ST_K_MUL;
               end
            end
            ST_K_MUL: begin
               clamp_ff <= clamp_ff | w_sat;
               sum_ff   <= sum_ff + SUM_BITS'(w_wdata);
               k_ff     <= k_ff + 1'b1;
               state_ff <= (k_ff + 1'b1 == cfg.num_states) ? ST_THR1 : ST_K_RD0;
            end
            ST_THR1: begin
               thr_hi_ff <= SUM_BITS'(sum_ff[SUM_BITS-1:Q_BITS] * rnd_ff);
               thr_lo_ff <= thr_lo_prod[2*Q_BITS-1:Q_BITS];
               state_ff  <= ST_THR2;
            end
            ST_THR2: begin
               thr_ff <= thr_hi_ff + SUM_BITS'(thr_lo_ff);
               cum_ff <= '0;
               k_ff   <= '0;
               if (sum_ff == '0) begin
                  s_ff     <= cur_ff;
                  up_ff    <= 1'b1;
                  step_ff  <= STEP_PREV;
                  state_ff <= ST_UPD_RD;
               end else begin
                  state_ff <= ST_SEL_RD;
               end
            end
            ST_SEL_RD: begin
               state_ff <= ST_SEL_CHK;
            end
            ST_SEL_CHK: begin
               cum_ff <= cum_in;
               if ((cum_in > thr_ff) || (k_ff + 1'b1 == cfg.num_states)) begin
                  s_ff     <= k_idx;
                  up_ff    <= 1'b1;
                  step_ff  <= STEP_PREV;
                  state_ff <= ST_UPD_RD;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_SEL_RD;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_state_ff  <= s_ff;
                  rsp_status_ff <= bad_ff ? STATUS_RANGE :
                                   (clamp_ff ? STATUS_CLAMP : STATUS_OK);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_state_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: sim/hmm_gibbs_state_resampler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmm_gibbs_state_resampler_top_test
// Self-checking bench for the HMM Gibbs state resampler. A directed table of
// tokens comes first, then per configuration a small corpus is counted in and
// its tokens are resampled at random, mixed with noise tokens. Each untyped
// result is compared with a local model of the count tables and weighted draw.
// ----------------------------------------------------------------------------
module hmm_gibbs_state_resampler_top_test;
   import hgsr_pkg::*;

   localparam logic [19:0] CNT_MAX    = 20'hFFFFF;
   localparam logic [63:0] Q32_CAP    = 64'hFFFF_FFFF;
   localparam logic [63:0] WEIGHT_CAP = (64'd1 << 58) - 64'd1;

   typedef struct packed {
      logic        cmd;
      logic [11:0] word;
      logic [3:0]  cur;
      logic [3:0]  prv;
      logic [3:0]  nxt;
      logic        hp;
      logic        hn;
      logic [31:0] rnd;
   } token_type;

   typedef struct packed {
      logic [3:0] state;
      logic [1:0] status;
   } outcome_type;

   typedef struct packed {
      token_type   tok;
      logic        typed;
      outcome_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   hmm_gibbs_state_resampler_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of the count tables and configuration
   logic [19:0] trans_cnt [256];
   logic [19:0] out_tot [16];
   logic [19:0] emit_cnt [65536];
   logic [19:0] state_tot [16];
   int unsigned cfg_k = 16, cfg_v = 4096, cfg_a = 256, cfg_b = 256;
   bit clamp_seen;

   outcome_type pending_q[$];
   int errors = 0;
   int send_idle = 0, recv_stall = 0, hold_cycles = 0;

   function automatic logic [19:0] cnt_up(input logic [19:0] c);
      if (c >= CNT_MAX) begin
         clamp_seen = 1'b1;
         return CNT_MAX;
      end
      return c + 20'd1;
   endfunction

   function automatic logic [19:0] cnt_down(input logic [19:0] c);
      if (c == 0) begin
         clamp_seen = 1'b1;
         return c;
      end
      return c - 20'd1;
   endfunction

   // Q32 quotient, truncated, capped just below one
   function automatic logic [63:0] q32_ratio(input logic [63:0] num, input logic [63:0] den);
      if (den == 0) begin
         if (num != 0) clamp_seen = 1'b1;
         return (num != 0) ? Q32_CAP : 64'd0;
      end
      if (num >= den) begin
         if (num > den) clamp_seen = 1'b1;
         return Q32_CAP;
      end
      return (num << 32) / den;
   endfunction

   function automatic logic [63:0] mul_q88(input logic [63:0] p, input logic [63:0] t2);
      logic [63:0] hi, lo, w;
      hi = p * (t2 >> 20);
      lo = (p * (t2 & 64'hFFFFF)) >> 8;
      if (hi > (WEIGHT_CAP >> 12)) begin
         clamp_seen = 1'b1;
         return WEIGHT_CAP;
      end
      w = (hi << 12) + lo;
      if (w > WEIGHT_CAP) begin
         clamp_seen = 1'b1;
         return WEIGHT_CAP;
      end
      return w;
   endfunction

   // applies one token to the tables and returns the sampled state
   function automatic outcome_type apply_token(input token_type t);
      outcome_type r;
      logic bad;
      logic [63:0] sum, thr, cum, t1, t2, t3, w, num, den;
      logic [63:0] wbuf [16];
      logic [3:0] pick;
      int k;
      bad = cfg_k < 2 || cfg_k > 16 || cfg_v < 1 || cfg_v > 4096 || cfg_a == 0 ||
            cfg_b == 0 || t.word >= cfg_v || t.cur >= cfg_k ||
            (t.hn && t.nxt >= cfg_k) || (t.cmd == CMD_RESAMPLE && t.hp && t.prv >= cfg_k);
      r.state = t.cur;
      r.status = STATUS_RANGE;
      if (bad) return r;
      clamp_seen = 1'b0;
      if (t.cmd == CMD_COUNT) begin
         emit_cnt[{t.cur, t.word}] = cnt_up(emit_cnt[{t.cur, t.word}]);
         state_tot[t.cur] = cnt_up(state_tot[t.cur]);
         if (t.hn) begin
            trans_cnt[{t.cur, t.nxt}] = cnt_up(trans_cnt[{t.cur, t.nxt}]);
            out_tot[t.cur] = cnt_up(out_tot[t.cur]);
         end
         r.status = clamp_seen ? STATUS_CLAMP : STATUS_OK;
         return r;
      end
      // take the token out
      if (t.hp) begin
         trans_cnt[{t.prv, t.cur}] = cnt_down(trans_cnt[{t.prv, t.cur}]);
         out_tot[t.prv] = cnt_down(out_tot[t.prv]);
      end
      if (t.hn) begin
         trans_cnt[{t.cur, t.nxt}] = cnt_down(trans_cnt[{t.cur, t.nxt}]);
         out_tot[t.cur] = cnt_down(out_tot[t.cur]);
      end
      emit_cnt[{t.cur, t.word}] = cnt_down(emit_cnt[{t.cur, t.word}]);
      state_tot[t.cur] = cnt_down(state_tot[t.cur]);
      // per-state weights
      sum = 0;
      for (k = 0; k < cfg_k; k++) begin
         t2 = 0;
         t3 = 0;
         t1 = q32_ratio(64'(emit_cnt[{4'(k), t.word}]) * 256 + cfg_b,
                        64'(state_tot[k]) * 256 + 64'(cfg_v) * cfg_b);
         if (t.hp) t2 = 64'(trans_cnt[{t.prv, 4'(k)}]) * 256 + cfg_a;
         if (t.hn) begin
            num = 64'(trans_cnt[{4'(k), t.nxt}]) * 256 + cfg_a;
            den = 64'(out_tot[k]) * 256 + 64'(cfg_k) * cfg_a;
            if (t.hp && t.prv == k) begin
               den += 256;
               if (k == t.nxt) num += 256;
            end
            t3 = q32_ratio(num, den);
         end
         if (t.hp && t.hn) w = mul_q88((t1 * t3) >> 32, t2);
         else if (t.hn) w = (t1 * t3) >> 32;
         else if (t.hp) w = mul_q88(t1, t2);
         else w = t1;
         wbuf[k] = w;
         sum += w;
      end
      // cumulative draw
      pick = t.cur;
      if (sum != 0) begin
         thr = (sum >> 32) * t.rnd + (((sum & Q32_CAP) * t.rnd) >> 32);
         cum = 0;
         pick = 4'(cfg_k - 1);
         for (k = 0; k < cfg_k; k++) begin
            cum += wbuf[k];
            if (cum > thr) begin
               pick = 4'(k);
               break;
            end
         end
      end
      // put it back under the drawn state
      if (t.hp) begin
         trans_cnt[{t.prv, pick}] = cnt_up(trans_cnt[{t.prv, pick}]);
         out_tot[t.prv] = cnt_up(out_tot[t.prv]);
      end
      if (t.hn) begin
         trans_cnt[{pick, t.nxt}] = cnt_up(trans_cnt[{pick, t.nxt}]);
         out_tot[pick] = cnt_up(out_tot[pick]);
      end
      emit_cnt[{pick, t.word}] = cnt_up(emit_cnt[{pick, t.word}]);
      state_tot[pick] = cnt_up(state_tot[pick]);
      r.state = pick;
      r.status = clamp_seen ? STATUS_CLAMP : STATUS_OK;
      return r;
   endfunction

   // result side: check each transfer, stall at random or for a long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_q.size() == 0) begin
               $error("unexpected result: new_state %0d status %0d",
                      rsp_tdata[3:0], rsp_tuser);
               errors++;
            end else begin
               outcome_type w;
               w = pending_q.pop_front();
               if (rsp_tdata[3:0] !== w.state) begin
                  $error("new_state: expected %0d, got %0d", w.state, rsp_tdata[3:0]);
                  errors++;
               end
               if (rsp_tuser !== w.status) begin
                  $error("status: expected %0d, got %0d", w.status, rsp_tuser);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // APB write followed by a read-back of the same register
   task automatic csr_write(input reg_index_type idx, input int unsigned val,
                            input int unsigned mask);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== (val & mask)) begin
         $error("csr %0d readback: expected %0h, got %0h", idx, val & mask, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      unique case (idx)
         REG_NUM_STATES: cfg_k = val & mask;
         REG_VOCAB_SIZE: cfg_v = val & mask;
         REG_ALPHA:      cfg_a = val & mask;
         REG_BETA:       cfg_b = val & mask;
      endcase
   endtask

   task automatic set_config(input int unsigned k, input int unsigned v,
                             input int unsigned a, input int unsigned b);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      csr_write(REG_NUM_STATES, k, 32'h1F);
      csr_write(REG_VOCAB_SIZE, v, 32'h1FFF);
      csr_write(REG_ALPHA, a, 32'hFFFF);
      csr_write(REG_BETA, b, 32'hFFFF);
   endtask

   // offers one token; the model runs at the transfer
   task automatic send_token(input token_type t, input logic typed, input outcome_type want,
                             output outcome_type got);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tuser <= t.cmd;
      req_tdata <= {6'd0, t.rnd, t.hn, t.hp, t.nxt, t.prv, t.cur, t.word};
      do @(posedge clock); while (!req_tready);
      got = apply_token(t);
      pending_q.push_back(typed ? want : got);
   endtask

   function automatic token_type noise_token();
      token_type t;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      t = raw[$bits(token_type)-1:0];
      t.rnd = $urandom;
      return t;
   endfunction

   // small corpus counted in, then resampled token by token
   logic [11:0] corp_word [32];
   logic [3:0]  corp_lab [32];
   bit          corp_head [32];

   task automatic run_phase(input int n_items);
      token_type t;
      outcome_type got;
      int n, i, sent, kk;
      kk = (cfg_k < 2) ? 2 : (cfg_k > 16 ? 16 : cfg_k);
      sent = 0;
      while (sent < n_items) begin
         n = $urandom_range(1, 32);
         for (i = 0; i < n; i++) begin
            corp_head[i] = (i == 0) || ($urandom_range(4) == 0);
            corp_word[i] = $urandom_range(1) ? 12'($urandom_range(0, (cfg_v > 16 ? 15 : cfg_v - 1)))
                                             : 12'($urandom_range(0, cfg_v - 1));
            corp_lab[i] = 4'($urandom_range(0, kk - 1));
         end
         for (i = 0; i <= n * 5 && sent < n_items; i++) begin
            if ($urandom_range(9) == 0) begin
               send_token(noise_token(), 1'b0, '0, got);
            end else begin
               int p;
               p = (i < n) ? i : $urandom_range(0, n - 1);
               t.cmd = (i < n) ? CMD_COUNT : CMD_RESAMPLE;
               t.word = corp_word[p];
               t.cur = corp_lab[p];
               t.hp = !corp_head[p];
               t.prv = t.hp ? corp_lab[p - 1] : 4'($urandom);
               t.hn = (p + 1 < n) && !corp_head[p + 1];
               t.nxt = t.hn ? corp_lab[p + 1] : 4'($urandom);
               t.rnd = $urandom;
               send_token(t, 1'b0, '0, got);
               if (t.cmd == CMD_RESAMPLE) corp_lab[p] = got.state;
            end
            sent++;
         end
      end
   endtask

   // directed tokens; typed rows carry their known outcome
   localparam int N_ROWS = 13;
   localparam int SPLIT = 5;
   row_type dir_rows [N_ROWS] = '{
      // empty tables, reset configuration
      '{'{CMD_COUNT,    12'd0,    4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'd0}, 1'b1, '{4'd0,  STATUS_OK}},
      '{'{CMD_COUNT,    12'd4095, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1, 32'hFFFFFFFF}, 1'b1,
        '{4'd15, STATUS_OK}},
      '{'{CMD_RESAMPLE, 12'd4095, 4'd15, 4'd0,  4'd0,  1'b0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{CMD_RESAMPLE, 12'd7,    4'd3,  4'd0,  4'd2,  1'b1, 1'b1, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{CMD_RESAMPLE, 12'd0,    4'd0,  4'd15, 4'd0,  1'b1, 1'b0, 32'h80000000}, 1'b0, '0},
      // K=4, V=100, alpha minimum, beta maximum
      '{'{CMD_COUNT,    12'd100,  4'd1,  4'd0,  4'd0,  1'b0, 1'b0, 32'd0}, 1'b1, '{4'd1,  STATUS_RANGE}},
      '{'{CMD_COUNT,    12'd5,    4'd4,  4'd0,  4'd0,  1'b0, 1'b0, 32'd0}, 1'b1, '{4'd4,  STATUS_RANGE}},
      '{'{CMD_COUNT,    12'd5,    4'd2,  4'd0,  4'd4,  1'b0, 1'b1, 32'd0}, 1'b1, '{4'd2,  STATUS_RANGE}},
      '{'{CMD_RESAMPLE, 12'd5,    4'd2,  4'd9,  4'd1,  1'b1, 1'b1, 32'd0}, 1'b1, '{4'd2,  STATUS_RANGE}},
      '{'{CMD_COUNT,    12'd5,    4'd2,  4'd9,  4'd2,  1'b1, 1'b1, 32'd0}, 1'b1, '{4'd2,  STATUS_OK}},
      '{'{CMD_COUNT,    12'd99,   4'd2,  4'd0,  4'd3,  1'b0, 1'b1, 32'd0}, 1'b1, '{4'd2,  STATUS_OK}},
      // middle token with prev == k == next
      '{'{CMD_RESAMPLE, 12'd5,    4'd2,  4'd2,  4'd2,  1'b1, 1'b1, 32'h12345678}, 1'b0, '0},
      '{'{CMD_RESAMPLE, 12'd99,   4'd2,  4'd0,  4'd3,  1'b0, 1'b1, 32'hFFFFFFFF}, 1'b0, '0}
   };

   initial begin
      outcome_type got;
      int i;
      foreach (emit_cnt[j]) emit_cnt[j] = '0;
      foreach (trans_cnt[j]) trans_cnt[j] = '0;
      for (i = 0; i < 16; i++) begin
         out_tot[i] = '0;
         state_tot[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      for (i = 0; i < N_ROWS; i++) begin
         if (i == SPLIT) set_config(4, 100, 1, 65535);
         send_token(dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].want, got);
      end

      // random part over several settings and idling phases
      set_config(16, 4096, 256, 256);
      hold_cycles = 4000;
      run_phase(400);
      send_idle = 50;
      set_config(2, 1, 1, 1);
      run_phase(400);
      send_idle = 0;
      recv_stall = 50;
      set_config(4, 64, 65535, 65535);
      run_phase(300);
      send_idle = 38;
      recv_stall = 38;
      set_config(8, 16, 128, 512);
      run_phase(300);
      send_idle = 0;
      recv_stall = 0;
      set_config(16, 300, 1, 65535);
      hold_cycles = 4000;
      run_phase(400);
      // illegal settings: everything is refused
      set_config(17, 4096, 0, 256);
      run_phase(40);
      set_config(1, 0, 256, 0);
      run_phase(40);

      @(posedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #200ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
sv/hgsr_pkg.sv
sv/hgsr_ram.sv
sv/hgsr_div.sv
sv/hgsr_csr.sv
sv/hmm_gibbs_state_resampler_top.sv
sim/hmm_gibbs_state_resampler_top_test.sv
